// ===== src/bpa_pkg.sv =====
package bpa_pkg;

    localparam int SLOTS      = 256;
    localparam int WORD_BITS  = 32;
    localparam int WBIT_W     = $clog2(WORD_BITS);
    localparam int MAP_WORDS  = (SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int IDX_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int SLOT_W     = 8;
    localparam int CAP_W      = 9;
    localparam int ADDR_W     = 32;
    localparam int SIZE_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [1:0] STAT_DONE   = 2'd0;
    localparam logic [1:0] STAT_FULL   = 2'd1;
    localparam logic [1:0] STAT_REJECT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAP  = 2'd2;

    typedef struct packed {
        logic              mode;
        logic [ADDR_W-1:0] free_address;
    } t_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [ADDR_W-1:0] object_address;
        logic [SLOT_W-1:0] slot_index;
        logic [CAP_W-1:0]  free_slots;
    } t_res;

endpackage

// ===== src/bpa_div.sv =====
module bpa_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [bpa_pkg::ADDR_W-1:0] i_dividend,
    input  logic [bpa_pkg::SIZE_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [bpa_pkg::ADDR_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(bpa_pkg::ADDR_W);

    logic                       r_active;
    logic                       r_done;
    logic [CNT_W-1:0]           r_cnt;
    logic [bpa_pkg::SIZE_W-1:0] r_rem;
    logic [bpa_pkg::SIZE_W-1:0] r_div;
    logic [bpa_pkg::ADDR_W-1:0] r_quo;

    logic [bpa_pkg::SIZE_W:0]   shifted;
    logic [bpa_pkg::SIZE_W:0]   diff;
    logic                       q_bit;

    // One restoring step per cycle: the dividend shifts out of the top of
    // r_quo while quotient bits shift in at the bottom.
    always_comb begin
        shifted = {r_rem, r_quo[bpa_pkg::ADDR_W-1]};
        diff    = shifted - {1'b0, r_div};
        q_bit   = (shifted >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_done   <= 1'b0;
            r_cnt    <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_active <= 1'b1;
                r_cnt    <= '0;
            end else if (r_active) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(bpa_pkg::ADDR_W - 1)) begin
                    r_active <= 1'b0;
                    r_done   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_active) begin
            r_quo <= {r_quo[bpa_pkg::ADDR_W-2:0], q_bit};
            r_rem <= q_bit ? diff[bpa_pkg::SIZE_W-1:0] : shifted[bpa_pkg::SIZE_W-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// ===== src/bitmap_pool_allocator.sv =====
// Allocator for a pool of equal-size objects, tracked by a used-slot bitmap held in a small
// word-wide RAM (eight 32-bit words). A request is accepted while o_busy is low; the result
// is driven on o_res for exactly one cycle with o_res_valid high, and the receiver cannot stall
// it, so it must be taken on that cycle. An alloc, or a free that is rejected on its address,
// goes from acceptance to the result through S_ISSUE, which issues the first RAM read, then
// S_SCAN, one step per bitmap word for the combined search, update and free-slot count, and
// S_FIN, which forms the result. A free that passes the address check first converts its
// offset to a slot with a bit-serial divider in S_DIV before those steps. The bitmap
// reads as all free after reset without any clearing pass. Configuration writes are
// always ready and must only be made while the block is idle.
module bitmap_pool_allocator (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  bpa_pkg::t_req                  i_req,
    output logic                           o_res_valid,
    output bpa_pkg::t_res                  o_res,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [bpa_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bpa_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_ISSUE,
        S_SCAN,
        S_FIN
    } t_state;

    localparam int WB = bpa_pkg::WORD_BITS;
    localparam logic [bpa_pkg::CAP_W-1:0] SLOTS_CAP = bpa_pkg::CAP_W'(bpa_pkg::SLOTS);
    localparam logic [bpa_pkg::IDX_W-1:0] LAST_WORD = bpa_pkg::IDX_W'(bpa_pkg::MAP_WORDS - 1);

    t_state                      r_state;
    logic [bpa_pkg::ADDR_W-1:0]  r_base;
    logic [bpa_pkg::SIZE_W-1:0]  r_size;
    logic [bpa_pkg::CAP_W-1:0]   r_cap;
    logic                        r_mode;
    logic                        r_reject;
    logic                        r_found;
    logic [bpa_pkg::SLOT_W-1:0]  r_slot;
    logic [bpa_pkg::CAP_W-1:0]   r_cnt;
    logic [bpa_pkg::IDX_W-1:0]   r_scan_w;
    logic                        r_res_valid;
    bpa_pkg::t_res               r_res;

    logic [WB-1:0]               mem [bpa_pkg::MAP_WORDS];
    logic [bpa_pkg::MAP_WORDS-1:0] r_word_vld;
    logic [WB-1:0]               r_rd_data;
    logic                        r_rd_vld;

    logic [bpa_pkg::CAP_W-1:0]   cap_eff;
    logic                        accept;
    logic                        addr_bad;
    logic                        div_start;
    logic                        div_done;
    logic [bpa_pkg::ADDR_W-1:0]  div_quo;
    logic                        rd_en;
    logic [bpa_pkg::IDX_W-1:0]   rd_addr;
    logic [WB-1:0]               word_data;
    logic [WB-1:0]               word_mask;
    logic [WB-1:0]               avail;
    logic [bpa_pkg::WBIT_W-1:0]  low_bit;
    logic [WB-1:0]               new_data;
    logic                        wr_en;
    logic                        take;
    logic [bpa_pkg::WBIT_W:0]    cnt_word;
    logic [23:0]                 prod;
    logic [1:0]                  fin_status;

    assign cap_eff   = (r_cap > SLOTS_CAP) ? SLOTS_CAP : r_cap;
    assign accept    = i_start && (r_state == S_IDLE);
    assign addr_bad  = (i_req.free_address == '0) || (i_req.free_address < r_base)
                       || (r_size == '0);
    assign div_start = accept && (i_req.mode == bpa_pkg::MODE_FREE) && !addr_bad;

    bpa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (i_req.free_address - r_base),
        .i_divisor  (r_size),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Words are read in order; word w is written back while word w+1 is being read,
    // so a read never meets a pending write to the same word.
    always_comb begin
        rd_en   = (r_state == S_ISSUE) || ((r_state == S_SCAN) && (r_scan_w != LAST_WORD));
        rd_addr = (r_state == S_ISSUE) ? '0 : r_scan_w + 1'b1;
    end

    always_comb begin
        word_data = r_rd_vld ? r_rd_data : '0;
        for (int b = 0; b < WB; b++) begin
            word_mask[b] = ({1'b0, r_scan_w, bpa_pkg::WBIT_W'(b)} < cap_eff);
        end
        avail   = ~word_data & word_mask;
        low_bit = '0;
        for (int b = WB - 1; b >= 0; b--) begin
            if (avail[b]) begin
                low_bit = bpa_pkg::WBIT_W'(b);
            end
        end
        new_data = word_data;
        take     = 1'b0;
        wr_en    = 1'b0;
        if (r_state == S_SCAN) begin
            if (r_mode == bpa_pkg::MODE_ALLOC) begin
                if (!r_found && (avail != '0)) begin
                    take              = 1'b1;
                    wr_en             = 1'b1;
                    new_data[low_bit] = 1'b1;
                end
            end else if (!r_reject
                         && (r_slot[bpa_pkg::SLOT_W-1:bpa_pkg::WBIT_W] == r_scan_w)) begin
                wr_en = 1'b1;
                new_data[r_slot[bpa_pkg::WBIT_W-1:0]] = 1'b0;
            end
        end
        cnt_word = '0;
        for (int b = 0; b < WB; b++) begin
            cnt_word = cnt_word + (bpa_pkg::WBIT_W + 1)'(~new_data[b] & word_mask[b]);
        end
    end

    always_comb begin
        prod = 24'(r_slot) * 24'(r_size);
        if (r_mode == bpa_pkg::MODE_ALLOC) begin
            fin_status = r_found ? bpa_pkg::STAT_DONE : bpa_pkg::STAT_FULL;
        end else begin
            fin_status = r_reject ? bpa_pkg::STAT_REJECT : bpa_pkg::STAT_DONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_scan_w] <= new_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // A word that was never written reads as all free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_vld <= '0;
            r_rd_vld   <= 1'b0;
        end else begin
            if (wr_en) begin
                r_word_vld[r_scan_w] <= 1'b1;
            end
            if (rd_en) begin
                r_rd_vld <= r_word_vld[rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_size <= bpa_pkg::SIZE_W'(1);
            r_cap  <= SLOTS_CAP;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                bpa_pkg::CFG_BASE: r_base <= i_cfg_data;
                bpa_pkg::CFG_SIZE: r_size <= i_cfg_data[bpa_pkg::SIZE_W-1:0];
                bpa_pkg::CFG_CAP:  r_cap  <= i_cfg_data[bpa_pkg::CAP_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_res_valid <= 1'b0;
            r_found     <= 1'b0;
            r_reject    <= 1'b0;
            r_cnt       <= '0;
            r_scan_w    <= '0;
        end else begin
            r_res_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_mode   <= i_req.mode;
                        r_found  <= 1'b0;
                        r_cnt    <= '0;
                        r_scan_w <= '0;
                        r_slot   <= '0;
                        if (i_req.mode == bpa_pkg::MODE_FREE) begin
                            r_reject <= addr_bad;
                            r_state  <= addr_bad ? S_ISSUE : S_DIV;
                        end else begin
                            r_reject <= 1'b0;
                            r_state  <= S_ISSUE;
                        end
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_slot   <= div_quo[bpa_pkg::SLOT_W-1:0];
                        r_reject <= (div_quo >= bpa_pkg::ADDR_W'(cap_eff));
                        r_state  <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_cnt <= r_cnt + bpa_pkg::CAP_W'(cnt_word);
                    if (take) begin
                        r_found <= 1'b1;
                        r_slot  <= {r_scan_w, low_bit};
                    end
                    if (r_scan_w == LAST_WORD) begin
                        r_state <= S_FIN;
                    end else begin
                        r_scan_w <= r_scan_w + 1'b1;
                    end
                end
                S_FIN: begin
                    r_res_valid      <= 1'b1;
                    r_res.status     <= fin_status;
                    r_res.slot_index <= (fin_status == bpa_pkg::STAT_DONE) ? r_slot : '0;
                    r_res.free_slots <= r_cnt;
                    if ((r_mode == bpa_pkg::MODE_ALLOC) && r_found) begin
                        r_res.object_address <= r_base + bpa_pkg::ADDR_W'(prod);
                    end else begin
                        r_res.object_address <= '0;
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;
    assign o_cfg_ready = 1'b1;

endmodule

// ===== dv/tb_bitmap_pool_allocator.sv =====
module tb_bitmap_pool_allocator;
    timeunit 1ns;
    timeprecision 1ps;

    import bpa_pkg::*;

    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 95;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 60;

    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  cfg_index;
        logic [CFG_DATA_W-1:0] cfg_data;
        t_req                  req;
        bit                    typed;
        t_res                  reply;
    } t_plan_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_start;
    logic                  o_busy;
    t_req                  i_req;
    logic                  o_res_valid;
    t_res                  o_res;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Shadow copy of the pool: used bits and the three registers.
    logic [SLOTS-1:0]  used_map;
    logic [ADDR_W-1:0] pool_base;
    logic [SIZE_W-1:0] pool_size;
    logic [CAP_W-1:0]  pool_capacity;

    t_res      replies_due[$];
    t_plan_row plan[$];
    int        mismatches = 0;
    int        idle_pct   = 14;

    bitmap_pool_allocator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_req       (i_req),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int unsigned live_slots();
        return (pool_capacity > SLOTS) ? SLOTS : pool_capacity;
    endfunction

    // Applies one request to the shadow pool and returns the reply it should produce.
    function automatic t_res reply_for(t_req r);
        t_res        res;
        int unsigned cap;
        int unsigned s;
        int unsigned n;
        cap = live_slots();
        res = '0;
        if (r.mode == MODE_ALLOC) begin
            s = 0;
            while (s < cap && used_map[s]) s++;
            if (s < cap) begin
                used_map[s] = 1'b1;
                res.object_address = pool_base + s * pool_size;
                res.slot_index = SLOT_W'(s);
            end else begin
                res.status = STAT_FULL;
            end
        end else if (r.free_address == '0 || r.free_address < pool_base || pool_size == '0) begin
            res.status = STAT_REJECT;
        end else begin
            s = (r.free_address - pool_base) / pool_size;
            if (s >= cap) begin
                res.status = STAT_REJECT;
            end else begin
                used_map[s] = 1'b0;
                res.slot_index = SLOT_W'(s);
            end
        end
        n = 0;
        for (int i = 0; i < cap; i++) begin
            if (!used_map[i]) n++;
        end
        res.free_slots = CAP_W'(n);
        return res;
    endfunction

    function automatic t_req random_request();
        t_req        r;
        int unsigned cap;
        int unsigned roll;
        int unsigned first;
        int unsigned s;
        bit          hit;
        cap = live_slots();
        roll = $urandom_range(0, 99);
        r.mode = MODE_ALLOC;
        r.free_address = $urandom;
        if (roll >= 45) begin
            r.mode = MODE_FREE;
            if (roll < 85 && cap != 0) begin
                // Aim at a slot in use when there is one, so that most frees release something.
                first = $urandom_range(0, cap - 1);
                s = first;
                hit = 1'b0;
                for (int k = 0; k < cap && !hit; k++) begin
                    if (used_map[(first + k) % cap]) begin
                        s = (first + k) % cap;
                        hit = 1'b1;
                    end
                end
                r.free_address = pool_base + s * pool_size;
                if (pool_size > 1) r.free_address += $urandom_range(0, pool_size - 1);
            end else if (roll < 93) begin
                case ($urandom_range(0, 3))
                    0: r.free_address = '0;
                    1: r.free_address = pool_base - 1;
                    2: r.free_address = pool_base + cap * pool_size;
                    default: r.free_address = '1;
                endcase
            end
        end
        return r;
    endfunction

    function automatic t_plan_row cfg_row(logic [CFG_IDX_W-1:0] index,
                                          logic [CFG_DATA_W-1:0] data);
        t_plan_row row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.cfg_index = index;
        row.cfg_data = data;
        return row;
    endfunction

    function automatic t_plan_row req_row(logic mode, logic [ADDR_W-1:0] addr);
        t_plan_row row;
        row = '{default: '0};
        row.req.mode = mode;
        row.req.free_address = addr;
        return row;
    endfunction

    function automatic t_plan_row chk_row(logic mode, logic [ADDR_W-1:0] addr,
                                          logic [1:0] status, logic [ADDR_W-1:0] obj,
                                          logic [SLOT_W-1:0] slot, logic [CAP_W-1:0] left);
        t_plan_row row;
        row = req_row(mode, addr);
        row.typed = 1'b1;
        row.reply.status = status;
        row.reply.object_address = obj;
        row.reply.slot_index = slot;
        row.reply.free_slots = left;
        return row;
    endfunction

    // Called at a falling edge; returns at the falling edge after the request is taken,
    // with i_start still high so that back-to-back requests need no extra cycle.
    task automatic send_req(t_req r, bit typed, t_res reply);
        t_res model;
        i_cfg_valid <= 1'b0;
        while ($urandom_range(0, 99) < idle_pct) begin
            i_start <= 1'b0;
            @(negedge i_clk);
        end
        i_start <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (o_busy);
        model = reply_for(r);
        replies_due.push_back(typed ? reply : model);
        @(negedge i_clk);
    endtask

    // Registers only change while the block is idle and every reply has been seen.
    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        i_start <= 1'b0;
        while (replies_due.size() != 0 || o_busy) @(negedge i_clk);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_cfg_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (index)
            CFG_BASE: pool_base = data;
            CFG_SIZE: pool_size = data[SIZE_W-1:0];
            CFG_CAP:  pool_capacity = data[CAP_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatches++;
        if (mismatches <= 10) $display("%s: expected %0h, got %0h", what, want, got);
    endtask

    always @(posedge i_clk) begin : watch_replies
        t_res want;
        if (i_rst_n && o_res_valid) begin
            if (replies_due.size() == 0) begin
                note_mismatch("reply with no request waiting", '0, o_res.object_address);
            end else begin
                want = replies_due.pop_front();
                if (o_res.status !== want.status)
                    note_mismatch("status", want.status, o_res.status);
                if (o_res.object_address !== want.object_address)
                    note_mismatch("object_address", want.object_address, o_res.object_address);
                if (o_res.slot_index !== want.slot_index)
                    note_mismatch("slot_index", want.slot_index, o_res.slot_index);
                if (o_res.free_slots !== want.free_slots)
                    note_mismatch("free_slots", want.free_slots, o_res.free_slots);
            end
        end
    end

    initial begin : stall_guard
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_start && !o_busy) || o_res_valid || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("bitmap_pool_allocator: mismatch");
        $finish;
    end

    initial begin
        t_res                  no_reply;
        logic [CFG_DATA_W-1:0] cfg_word;

        i_rst_n       = 1'b0;
        i_start       = 1'b0;
        i_req         = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        pool_base     = '0;
        pool_size     = 16'd1;
        pool_capacity = 9'd256;
        used_map      = '0;
        no_reply      = '0;

        // Reset pool: base 0, stride 1, all 256 slots.
        plan.push_back(chk_row(MODE_ALLOC, 32'h0, STAT_DONE, 32'h0, 8'd0, 9'd255));
        plan.push_back(chk_row(MODE_ALLOC, 32'h0, STAT_DONE, 32'h1, 8'd1, 9'd254));
        plan.push_back(chk_row(MODE_FREE, 32'h0, STAT_REJECT, 32'h0, 8'd0, 9'd254));
        plan.push_back(chk_row(MODE_FREE, 32'h1, STAT_DONE, 32'h0, 8'd1, 9'd255));
        plan.push_back(chk_row(MODE_FREE, 32'h1, STAT_DONE, 32'h0, 8'd1, 9'd255));
        plan.push_back(chk_row(MODE_FREE, 32'h100, STAT_REJECT, 32'h0, 8'd0, 9'd255));
        plan.push_back(chk_row(MODE_FREE, 32'hFFFF_FFFF, STAT_REJECT, 32'h0, 8'd0, 9'd255));
        plan.push_back(cfg_row(CFG_BASE, 32'h1000));
        plan.push_back(cfg_row(CFG_SIZE, 32'h10));
        plan.push_back(chk_row(MODE_FREE, 32'h0FFF, STAT_REJECT, 32'h0, 8'd0, 9'd255));
        plan.push_back(chk_row(MODE_FREE, 32'h1000, STAT_DONE, 32'h0, 8'd0, 9'd256));
        plan.push_back(chk_row(MODE_ALLOC, 32'h0, STAT_DONE, 32'h1000, 8'd0, 9'd255));
        plan.push_back(chk_row(MODE_ALLOC, 32'h0, STAT_DONE, 32'h1010, 8'd1, 9'd254));
        plan.push_back(req_row(MODE_FREE, 32'h101F));
        plan.push_back(cfg_row(CFG_CAP, 32'd2));
        plan.push_back(req_row(MODE_ALLOC, 32'h0));
        plan.push_back(chk_row(MODE_ALLOC, 32'h0, STAT_FULL, 32'h0, 8'd0, 9'd0));
        plan.push_back(chk_row(MODE_FREE, 32'h1020, STAT_REJECT, 32'h0, 8'd0, 9'd0));
        plan.push_back(cfg_row(CFG_CAP, 32'd0));
        plan.push_back(chk_row(MODE_ALLOC, 32'h0, STAT_FULL, 32'h0, 8'd0, 9'd0));
        plan.push_back(chk_row(MODE_FREE, 32'h1000, STAT_REJECT, 32'h0, 8'd0, 9'd0));
        // Capacity above the pool size saturates; a zero stride puts every object at base.
        plan.push_back(cfg_row(CFG_CAP, 32'd511));
        plan.push_back(cfg_row(CFG_SIZE, 32'd0));
        plan.push_back(chk_row(MODE_ALLOC, 32'h0, STAT_DONE, 32'h1000, 8'd2, 9'd253));
        plan.push_back(chk_row(MODE_FREE, 32'h1000, STAT_REJECT, 32'h0, 8'd0, 9'd253));
        plan.push_back(cfg_row(CFG_BASE, 32'hFFFF_0000));
        plan.push_back(cfg_row(CFG_SIZE, 32'hFFFF));
        plan.push_back(req_row(MODE_ALLOC, 32'h0));
        plan.push_back(req_row(MODE_FREE, 32'hFFFF_FFFF));
        plan.push_back(req_row(MODE_FREE, 32'hFFFF_0000));
        plan.push_back(cfg_row(CFG_BASE, 32'hFFFF_FFFF));
        plan.push_back(cfg_row(CFG_SIZE, 32'd1));
        plan.push_back(cfg_row(CFG_CAP, 32'd256));
        plan.push_back(req_row(MODE_FREE, 32'hFFFF_FFFF));
        plan.push_back(req_row(MODE_ALLOC, 32'h0));
        plan.push_back(req_row(MODE_ALLOC, 32'h0));
        plan.push_back(cfg_row(CFG_CAP, 32'd1));
        plan.push_back(chk_row(MODE_ALLOC, 32'h0, STAT_FULL, 32'h0, 8'd0, 9'd0));
        plan.push_back(req_row(MODE_FREE, 32'hFFFF_FFFF));

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].is_cfg)
                write_reg(plan[i].cfg_index, plan[i].cfg_data);
            else
                send_req(plan[i].req, plan[i].typed, plan[i].reply);
        end

        for (int p = 0; p < PHASES; p++) begin
            idle_pct = (p == 3) ? 0 : 14;
            case ($urandom_range(0, 4))
                0: cfg_word = '0;
                1: cfg_word = '1;
                2: cfg_word = $urandom_range(0, 65535);
                3: cfg_word = 32'hFFFF_0000 | $urandom_range(0, 65535);
                default: cfg_word = $urandom;
            endcase
            write_reg(CFG_BASE, cfg_word);
            case ($urandom_range(0, 9))
                0: cfg_word = 32'd0;
                1: cfg_word = 32'd1;
                2: cfg_word = 32'hFFFF;
                3, 4, 5: cfg_word = $urandom_range(1, 64);
                default: cfg_word = $urandom_range(1, 65535);
            endcase
            write_reg(CFG_SIZE, cfg_word);
            case ($urandom_range(0, 9))
                0: cfg_word = 32'd0;
                1: cfg_word = 32'd1;
                2: cfg_word = 32'd256;
                3: cfg_word = $urandom_range(257, 511);
                4, 5, 6: cfg_word = $urandom_range(1, 16);
                default: cfg_word = $urandom_range(1, 256);
            endcase
            write_reg(CFG_CAP, cfg_word);
            repeat (ITEMS_PER_PHASE) send_req(random_request(), 1'b0, no_reply);
        end

        i_start <= 1'b0;
        while (replies_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0 && replies_due.size() == 0)
            $display("bitmap_pool_allocator: match");
        else
            $display("bitmap_pool_allocator: mismatch");
        $finish;
    end

endmodule
